### rtl/olie_pkg.sv
// Package for the ordered list insert engine.
// Holds operation codes, status codes and default sizes; no dependencies.

package olie_pkg;

    localparam int DEPTH_DEFAULT     = 32;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam logic [2:0] OP_PUT_BACK   = 3'd0;
    localparam logic [2:0] OP_PUT_FRONT  = 3'd1;
    localparam logic [2:0] OP_TAKE_BACK  = 3'd2;
    localparam logic [2:0] OP_TAKE_FRONT = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

endpackage

### rtl/olie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module olie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ordered_list_insert_engine.sv
// Top level of the ordered list insert engine: circular list in a RAM under a sequencer.
// Depends on olie_pkg and olie_ram.
//
//  channel   handshake        payload                              direction
//  command   start / busy     operation, value, key                in
//  result    done (strobe)    popped_value, status, entry_count    out
//
// A command is taken when start is high and busy is low; busy stays high until its result.
// Push and commands rejected at dispatch end in S_DISPATCH, pop in S_POP_WAIT.
// Insert: S_SEARCH finds the first entry matching key (else not found), S_SHIFT moves
// the tail back, S_PLACE adds value; one RAM read and write per cycle, one compare unit.
// Reset empties the list at once; entry contents stay undefined until written.
// The result strobe lasts one cycle and cannot be held off by the receiver.

module ordered_list_insert_engine
    import olie_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2:0]                 operation,
    input  logic signed [31:0]         value,
    input  logic signed [31:0]         key,
    output logic                       busy,
    output logic                       done,
    output logic signed [31:0]         popped_value,
    output logic [1:0]                 status,
    output logic [$clog2(DEPTH+1)-1:0] entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_PLACE
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [2:0]            op_reg, op_next;
    logic [WORD_BITS-1:0]  value_reg, value_next;
    logic [WORD_BITS-1:0]  key_reg, key_next;
    logic                  done_reg, done_next;
    logic signed [31:0]    popped_reg, popped_next;
    status_t               status_reg, status_next;

    logic                  ram_we;
    logic                  wr_front;
    logic [CW-1:0]         wr_lpos;
    logic [CW-1:0]         rd_lpos;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  rd_data;

    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         head_dec;
    logic                  full;
    logic                  empty;
    logic signed [63:0]    value_ext;
    logic signed [63:0]    key_ext;
    logic signed [63:0]    rd_ext;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign value_ext = 64'(value);
    assign key_ext   = 64'(key);
    assign rd_ext    = 64'($signed(rd_data));

    assign wr_addr = wr_front ? head_dec : to_phys(head_reg, wr_lpos);
    assign rd_addr = to_phys(head_reg, rd_lpos);

    olie_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        popped_next = popped_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        wr_front    = 1'b0;
        wr_lpos     = '0;
        rd_lpos     = '0;
        wr_data     = value_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    value_next = value_ext[WORD_BITS-1:0];
                    key_next   = key_ext[WORD_BITS-1:0];
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                popped_next = '0;
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                case (op_reg)
                    OP_PUT_BACK:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            wr_lpos    = count_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_PUT_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            wr_front   = 1'b1;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_TAKE_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_lpos    = count_reg - CW'(1);
                            count_next = count_reg - CW'(1);
                            done_next  = 1'b0;
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_TAKE_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_lpos    = '0;
                            head_next  = head_inc;
                            count_next = count_reg - CW'(1);
                            done_next  = 1'b0;
                            state_next = S_POP_WAIT;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (empty)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            rd_lpos    = '0;
                            idx_next   = '0;
                            done_next  = 1'b0;
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                popped_next = rd_ext[31:0];
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_SEARCH:
            begin
                if (rd_data == key_reg)
                begin
                    rd_lpos    = count_reg - CW'(1);
                    j_next     = count_reg;
                    state_next = S_SHIFT;
                end
                else if (idx_reg == count_reg - CW'(1))
                begin
                    popped_next = '0;
                    status_next = ST_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_lpos  = idx_reg + CW'(1);
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_SHIFT:
            begin
                ram_we  = 1'b1;
                wr_lpos = j_reg;
                wr_data = rd_data;
                if (j_reg - CW'(1) == idx_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    rd_lpos = j_reg - CW'(2);
                    j_next  = j_reg - CW'(1);
                end
            end

            S_PLACE:
            begin
                ram_we      = 1'b1;
                wr_lpos     = idx_reg;
                wr_data     = value_reg;
                count_next  = count_reg + CW'(1);
                popped_next = '0;
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            popped_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        op_reg    <= op_next;
        value_reg <= value_next;
        key_reg   <= key_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign entry_count  = count_reg;

endmodule

### rtl/olie_checker.sv
// Port-level checker for the ordered list insert engine, bound to the top level.
// Depends on olie_pkg and ordered_list_insert_engine.

module olie_port_props
    import olie_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic signed [31:0]         popped_value,
    input logic [1:0]                 status,
    input logic [$clog2(DEPTH+1)-1:0] entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not raise busy");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (popped_value == 0 && entry_count == '0))
        else $error("empty status with data or entries");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == CW'(DEPTH)))
        else $error("full status on a list that is not full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= CW'(DEPTH)))
        else $error("entry count above depth");

endmodule

bind ordered_list_insert_engine olie_port_props #(
    .DEPTH (DEPTH)
) u_olie_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count)
);
